// ===== hw/rtl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the touch report decoder
// header codes, field widths, scaling divisors and their reciprocals
// ----------------------------------------------------------------------------
package trd_pkg;

	// report header codes
	localparam logic [7:0] HDR_PEN_DOWN = 8'h81;
	localparam logic [7:0] HDR_PEN_UP   = 8'h80;

	// field widths
	localparam int BYTE_W = 8;
	localparam int RAW_W  = 16;
	localparam int RES_W  = 11;
	localparam int X_W    = 14;
	localparam int Y_W    = 15;

	// product of a raw coordinate and a resolution
	localparam int PROD_W = RAW_W + RES_W;
	// quotient width before saturation
	localparam int QUOT_W = 15;

	// raw y offset
	localparam int Y_OFFSET = 30;

	// constant divisors and fixed point reciprocals, floor(2^s / d)
	localparam int X_SPAN      = 4090;
	localparam int Y_SPAN      = 4070;
	localparam int RECIP_SHIFT = 27;
	localparam int RECIP_W     = 16;
	localparam int X_RECIP     = (2 ** RECIP_SHIFT) / X_SPAN;
	localparam int Y_RECIP     = (2 ** RECIP_SHIFT) / Y_SPAN;
	localparam int EST_W       = PROD_W + RECIP_W;

	// coordinate saturation limit
	localparam int COORD_MAX = 16383;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_X_RES = 1'b0,
		REG_Y_RES = 1'b1
	} reg_index_t;

	localparam logic [RES_W-1:0] X_RES_RESET = 11'd800;
	localparam logic [RES_W-1:0] Y_RES_RESET = 11'd480;

	// one assembled report on its way to the scaler
	typedef struct packed {
		logic             pen_down;
		logic [RAW_W-1:0] x_raw;
		logic [RAW_W-1:0] y_mag;
		logic             y_neg;
	} report_t;

endpackage

// ===== hw/rtl/trd_parser.sv =====
// ----------------------------------------------------------------------------
// trd_parser: header hunt and report byte collection
// assembles raw x and the y offset magnitude into a registered report
// ----------------------------------------------------------------------------
module trd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [trd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         rpt_valid,
	output trd_pkg::report_t             rpt,
	input  logic                         rpt_ready
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_X_LOW,
		PH_X_HIGH,
		PH_Y_LOW,
		PH_Y_HIGH
	} phase_t;

	phase_t                         phase_q;
	logic                           kind_q;
	logic [trd_pkg::RAW_W-1:0]      x_raw_q;
	logic [trd_pkg::BYTE_W-1:0]     y_low_q;
	logic                           rpt_valid_s1;
	trd_pkg::report_t               rpt_s1;

	logic [trd_pkg::RAW_W-1:0]      high_part;
	logic [trd_pkg::RAW_W-1:0]      y_raw;
	logic                           y_neg;
	logic [trd_pkg::RAW_W-1:0]      y_mag;
	logic                           take;
	logic                           rpt_load;

	// only the closing byte needs room in the report register
	assign in_ready = (phase_q != PH_Y_HIGH) || !rpt_valid_s1 || rpt_ready;
	assign take     = in_valid && in_ready;
	assign rpt_load = take && (phase_q == PH_Y_HIGH);

	assign high_part = {1'b0, rx_byte, 7'b0};
	assign y_raw     = trd_pkg::RAW_W'(y_low_q) + high_part;
	assign y_neg     = y_raw < trd_pkg::RAW_W'(trd_pkg::Y_OFFSET);
	assign y_mag     = y_neg ? (trd_pkg::RAW_W'(trd_pkg::Y_OFFSET) - y_raw)
	                         : (y_raw - trd_pkg::RAW_W'(trd_pkg::Y_OFFSET));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			kind_q       <= 1'b0;
			x_raw_q      <= '0;
			y_low_q      <= '0;
			rpt_valid_s1 <= 1'b0;
		end else begin
			if (rpt_load) begin
				rpt_valid_s1 <= 1'b1;
			end else if (rpt_ready) begin
				rpt_valid_s1 <= 1'b0;
			end
			if (take) begin
				unique case (phase_q)
					PH_X_LOW: begin
						x_raw_q <= trd_pkg::RAW_W'(rx_byte);
						phase_q <= PH_X_HIGH;
					end
					PH_X_HIGH: begin
						x_raw_q <= x_raw_q + high_part;
						phase_q <= PH_Y_LOW;
					end
					PH_Y_LOW: begin
						y_low_q <= rx_byte;
						phase_q <= PH_Y_HIGH;
					end
					PH_Y_HIGH: begin
						phase_q <= PH_IDLE;
					end
					default: begin
						if (rx_byte == trd_pkg::HDR_PEN_DOWN) begin
							kind_q  <= 1'b1;
							phase_q <= PH_X_LOW;
						end else if (rx_byte == trd_pkg::HDR_PEN_UP) begin
							kind_q  <= 1'b0;
							phase_q <= PH_X_LOW;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_load) begin
			rpt_s1.pen_down <= kind_q;
			rpt_s1.x_raw    <= x_raw_q;
			rpt_s1.y_mag    <= y_mag;
			rpt_s1.y_neg    <= y_neg;
		end
	end

	assign rpt_valid = rpt_valid_s1;
	assign rpt       = rpt_s1;

endmodule

// ===== hw/rtl/trd_scaler.sv =====
// ----------------------------------------------------------------------------
// trd_scaler: coordinate scaling pipeline
// resolution multiply, reciprocal quotient estimate, correction and output
// ----------------------------------------------------------------------------
module trd_scaler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rpt_valid,
	input  trd_pkg::report_t                  rpt,
	output logic                              rpt_ready,
	input  logic [trd_pkg::RES_W-1:0]         x_res,
	input  logic [trd_pkg::RES_W-1:0]         y_res,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              pen_down,
	output logic [trd_pkg::X_W-1:0]           x_pixel,
	output logic signed [trd_pkg::Y_W-1:0]    y_pixel
);

	localparam int PW = trd_pkg::PROD_W;
	localparam int QW = trd_pkg::QUOT_W;
	localparam int EW = trd_pkg::EST_W;
	localparam int SH = trd_pkg::RECIP_SHIFT;

	// stage 2: products
	logic                 valid_s2;
	logic                 pen_s2;
	logic                 neg_s2;
	logic [PW-1:0]        x_prod_s2;
	logic [PW-1:0]        y_prod_s2;

	// stage 3: quotient estimates
	logic                 valid_s3;
	logic                 pen_s3;
	logic                 neg_s3;
	logic [PW-1:0]        x_prod_s3;
	logic [PW-1:0]        y_prod_s3;
	logic [QW-1:0]        x_est_s3;
	logic [QW-1:0]        y_est_s3;

	// stage 4: result register
	logic                          valid_s4;
	logic                          pen_s4;
	logic [trd_pkg::X_W-1:0]       x_pix_s4;
	logic [trd_pkg::Y_W-1:0]       y_pix_s4;

	logic en2, en3, en4;

	logic [EW-1:0]        x_full_est;
	logic [EW-1:0]        y_full_est;
	logic [PW-1:0]        x_back;
	logic [PW-1:0]        y_back;
	logic [PW-1:0]        x_rem;
	logic [PW-1:0]        y_rem;
	logic [QW-1:0]        x_quot;
	logic [QW-1:0]        y_quot;
	logic [trd_pkg::X_W-1:0] x_sat;
	logic [trd_pkg::Y_W-1:0] y_sat;
	logic [trd_pkg::Y_W-1:0] y_signed;

	assign en4       = !valid_s4 || out_ready;
	assign en3       = !valid_s3 || en4;
	assign en2       = !valid_s2 || en3;
	assign rpt_ready = en2;

	assign x_full_est = EW'(x_prod_s2) * EW'(trd_pkg::X_RECIP);
	assign y_full_est = EW'(y_prod_s2) * EW'(trd_pkg::Y_RECIP);

	// estimate is exact or one low, a single remainder check fixes it
	assign x_back = PW'(x_est_s3) * PW'(trd_pkg::X_SPAN);
	assign y_back = PW'(y_est_s3) * PW'(trd_pkg::Y_SPAN);
	assign x_rem  = x_prod_s3 - x_back;
	assign y_rem  = y_prod_s3 - y_back;
	assign x_quot = x_est_s3 + QW'(x_rem >= PW'(trd_pkg::X_SPAN));
	assign y_quot = y_est_s3 + QW'(y_rem >= PW'(trd_pkg::Y_SPAN));

	assign x_sat = (x_quot > QW'(trd_pkg::COORD_MAX)) ? trd_pkg::X_W'(trd_pkg::COORD_MAX)
	                                                  : trd_pkg::X_W'(x_quot);
	assign y_sat = (y_quot > QW'(trd_pkg::COORD_MAX)) ? trd_pkg::Y_W'(trd_pkg::COORD_MAX)
	                                                  : trd_pkg::Y_W'(y_quot);
	assign y_signed = neg_s3 ? (trd_pkg::Y_W'(0) - y_sat) : y_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en2) begin
				valid_s2 <= rpt_valid;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pen_s2    <= rpt.pen_down;
			neg_s2    <= rpt.y_neg;
			x_prod_s2 <= PW'(rpt.x_raw) * PW'(x_res);
			y_prod_s2 <= PW'(rpt.y_mag) * PW'(y_res);
		end
		if (en3) begin
			pen_s3    <= pen_s2;
			neg_s3    <= neg_s2;
			x_prod_s3 <= x_prod_s2;
			y_prod_s3 <= y_prod_s2;
			x_est_s3  <= x_full_est[SH +: QW];
			y_est_s3  <= y_full_est[SH +: QW];
		end
		if (en4) begin
			pen_s4   <= pen_s3;
			x_pix_s4 <= x_sat;
			y_pix_s4 <= y_signed;
		end
	end

	assign out_valid = valid_s4;
	assign pen_down  = pen_s4;
	assign x_pixel   = x_pix_s4;
	assign y_pixel   = $signed(y_pix_s4);

endmodule

// ===== hw/rtl/touch_report_decoder.sv =====
// ----------------------------------------------------------------------------
// touch_report_decoder: pen report parser for a touch controller link
// finds a press or release header, collects four coordinate bytes and
// reports the coordinates scaled to the screen resolution
// ----------------------------------------------------------------------------
// a report's last byte is loaded into the parser's report register and then
// passes scaler stages s2, s3 and s4 to out_valid; bytes are taken one per cycle
// while the output is not stalled, the rate being set by the byte parser
// reset: arst_n clears the parser to header hunt, empties the pipeline and
// loads the resolutions with 800 and 480
module touch_report_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [trd_pkg::BYTE_W-1:0]        rx_byte,
	// event output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              pen_down,
	output logic [trd_pkg::X_W-1:0]           x_pixel,
	output logic signed [trd_pkg::Y_W-1:0]    y_pixel,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [0:0]                        cfg_index,
	input  logic [trd_pkg::RES_W-1:0]         cfg_data
);

	// resolution registers
	logic [trd_pkg::RES_W-1:0] x_res_q;
	logic [trd_pkg::RES_W-1:0] y_res_q;

	// report handoff between parser and scaler
	logic             rpt_valid;
	logic             rpt_ready;
	trd_pkg::report_t rpt;

	// configuration writes land immediately, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_res_q <= trd_pkg::X_RES_RESET;
			y_res_q <= trd_pkg::Y_RES_RESET;
		end else if (cfg_write) begin
			unique case (trd_pkg::reg_index_t'(cfg_index))
				trd_pkg::REG_X_RES: x_res_q <= cfg_data;
				trd_pkg::REG_Y_RES: y_res_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// header hunt and byte collection, one report register at its output
	trd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.rpt_valid (rpt_valid),
		.rpt       (rpt),
		.rpt_ready (rpt_ready)
	);

	// multiply by resolution, divide by the span constant, saturate
	// the last stage doubles as the output register, so stalls back up cleanly
	trd_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.rpt_valid (rpt_valid),
		.rpt       (rpt),
		.rpt_ready (rpt_ready),
		.x_res     (x_res_q),
		.y_res     (y_res_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pen_down  (pen_down),
		.x_pixel   (x_pixel),
		.y_pixel   (y_pixel)
	);

	// input stalls only when a finished event waits at the output
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with no waiting event");

	// a negative y comes only from the small offset below zero
	a_neg_y_small: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && y_pixel[trd_pkg::Y_W-1]) |-> (y_pixel >= -15))
		else $error("negative y coordinate out of range");

	// an x resolution write takes effect on the next cycle
	a_cfg_x_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && (cfg_index == trd_pkg::REG_X_RES)) |=> (x_res_q == $past(cfg_data)))
		else $error("x resolution write lost");

endmodule
